FILE: hw/rtl/crwt_pkg.sv
package crwt_pkg;

	// Command codes of an input beat.
	localparam logic [1:0] CMD_CHUNK = 2'd0;
	localparam logic [1:0] CMD_TICK  = 2'd1;
	localparam logic [1:0] CMD_START = 2'd2;
	localparam logic [1:0] CMD_NONE  = 2'd3;

	// Status codes of a status result.
	localparam logic [2:0] ST_NEW      = 3'd0;
	localparam logic [2:0] ST_DUP      = 3'd1;
	localparam logic [2:0] ST_OUTSIDE  = 3'd2;
	localparam logic [2:0] ST_BAD_IDX  = 3'd3;
	localparam logic [2:0] ST_BAD_SIZE = 3'd4;
	localparam logic [2:0] ST_INACTIVE = 3'd5;
	localparam logic [2:0] ST_TIMEOUT  = 3'd6;
	localparam logic [2:0] ST_OK       = 3'd7;

	// Result kinds.
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_WORD   = 1'b1;

	// Configuration register indexes.
	localparam logic [2:0] REG_START_OFFSET  = 3'd0;
	localparam logic [2:0] REG_TRANSFER_SIZE = 3'd1;
	localparam logic [2:0] REG_CHUNK_BYTES   = 3'd2;
	localparam logic [2:0] REG_CHUNK_TOTAL   = 3'd3;
	localparam logic [2:0] REG_WINDOW_CHUNKS = 3'd4;
	localparam logic [2:0] REG_ACK_LIMIT     = 3'd5;
	localparam logic [2:0] REG_ACK_DELAY     = 3'd6;
	localparam logic [2:0] REG_TIMEOUT       = 3'd7;

	localparam int BITMAP_WORDS_DEF = 4;
	localparam logic [23:0] MAX24 = 24'hFFFFFF;

	typedef struct packed {
		logic [23:0] start_offset;
		logic [23:0] transfer_size;
		logic [10:0] chunk_bytes;
		logic [22:0] chunk_total;
		logic [7:0]  window_chunks;
		logic [7:0]  ack_count_limit;
		logic [15:0] ack_delay_ticks;
		logic [31:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [22:0] chunk_num;
		logic [10:0] chunk_length;
		logic [31:0] now_ticks;
	} item_t;

	typedef struct packed {
		logic        kind;
		logic [2:0]  status;
		logic        save_chunk;
		logic [23:0] save_offset;
		logic [23:0] committed_offset;
		logic        out_of_order;
		logic        transfer_done;
		logic        ack_sent;
		logic [22:0] ack_base_index;
		logic [31:0] ack_word;
		logic        active;
		logic        last;
	} res_t;

	// Saturates a 26-bit sum to the 24-bit offset range.
	function automatic logic [23:0] sat24(input logic [25:0] v);
		sat24 = (v > {2'b00, MAX24}) ? MAX24 : v[23:0];
	endfunction

endpackage

FILE: hw/rtl/crwt_front.sv
// Input side: takes beats, drops unknown commands and holds up to two items.
module crwt_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  crwt_pkg::item_t    item,
	output logic               valid,
	output crwt_pkg::item_t    head,
	input  logic               take
);
	crwt_pkg::item_t ent_q [2];
	logic [1:0] cnt_q;
	logic       wr_q;
	logic       rd_q;
	logic       do_wr;
	logic       do_rd;

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign head  = ent_q[rd_q];
	assign do_wr = push && !full && (item.command != crwt_pkg::CMD_NONE);
	assign do_rd = take && valid;

	// Storage for accepted items.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			ent_q[wr_q] <= item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (do_wr) begin
				wr_q <= !wr_q;
			end
			if (do_rd) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
		end
	end
endmodule

FILE: hw/rtl/crwt_outq.sv
// Result side: two-entry queue of finished results.
module crwt_outq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  crwt_pkg::res_t wdata,
	output logic           full,
	output logic           empty,
	input  logic           pop,
	output crwt_pkg::res_t rdata
);
	crwt_pkg::res_t ent_q [2];
	logic [1:0] cnt_q;
	logic       wr_q;
	logic       rd_q;
	logic       do_wr;
	logic       do_rd;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = ent_q[rd_q];
	assign do_wr = wr && !full;
	assign do_rd = pop && !empty;

	// Storage for results.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			ent_q[wr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (do_wr) begin
				wr_q <= !wr_q;
			end
			if (do_rd) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
		end
	end
endmodule

FILE: hw/rtl/crwt_core.sv
// Back end: a sequencer that runs one item at a time against the window state.
module crwt_core #(
	parameter int BITMAP_WORDS = crwt_pkg::BITMAP_WORDS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  crwt_pkg::cfg_t  cfg,
	input  logic            in_valid,
	input  crwt_pkg::item_t in_item,
	output logic            in_take,
	input  logic            out_full,
	output logic            out_wr,
	output crwt_pkg::res_t  out_res
);
	localparam int BITS = BITMAP_WORDS * 32;
	localparam int RELW = $clog2(BITS);
	localparam int RUNW = $clog2(BITS + 1);
	localparam int NWW  = $clog2(BITMAP_WORDS + 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EVAL   = 3'd1;
	localparam logic [2:0] S_CHECK  = 3'd2;
	localparam logic [2:0] S_SLIDE  = 3'd3;
	localparam logic [2:0] S_COMMIT = 3'd4;
	localparam logic [2:0] S_DECIDE = 3'd5;
	localparam logic [2:0] S_EMIT_S = 3'd6;
	localparam logic [2:0] S_EMIT_W = 3'd7;

	logic [2:0] state_q;

	// Window state.
	logic [BITS-1:0] bmp_q;
	logic [22:0]     base_q;
	logic [23:0]     done_q;
	logic [7:0]      unacked_q;
	logic            gaps_q;
	logic [31:0]     last_time_q;
	logic            active_q;

	// Item under work and its partial results.
	crwt_pkg::item_t it_q;
	logic [31:0]     elapsed_q;
	logic [33:0]     prod_q;
	logic [RELW-1:0] rel_q;
	logic            below_q;
	logic            outside_q;
	logic [RUNW-1:0] run_q;
	logic [2:0]      status_q;
	logic            save_q;
	logic [23:0]     soff_q;
	logic            ooo_q;
	logic            ack_q;
	logic [NWW-1:0]  wi_q;

	logic [31:0]     elapsed;
	logic [9:0]      win;
	logic [23:0]     win_end;
	logic [NWW-1:0]  nwords;
	logic            gaps;
	logic [7:0]      uc_inc;
	logic            ack_now;
	logic            tick_ack;
	logic [25:0]     soff_sum;
	logic [25:0]     d_sum;
	logic [25:0]     file_end;
	logic [34:0]     last_end;
	logic            bad_size;

	assign elapsed  = it_q.now_ticks - last_time_q;
	assign win      = ({2'b00, cfg.window_chunks} > 10'(BITS)) ? 10'(BITS)
	                  : {2'b00, cfg.window_chunks};
	assign win_end  = {1'b0, base_q} + {14'd0, win};
	assign gaps     = |bmp_q;
	assign uc_inc   = (unacked_q == 8'd255) ? unacked_q : unacked_q + 8'd1;
	assign soff_sum = {2'b00, done_q}
	                  + ({{(26-RELW){1'b0}}, rel_q} * {15'd0, cfg.chunk_bytes});
	assign d_sum    = {2'b00, done_q}
	                  + ({{(26-RUNW){1'b0}}, run_q} * {15'd0, cfg.chunk_bytes});
	assign file_end = {2'b00, cfg.start_offset} + {2'b00, cfg.transfer_size};
	assign last_end = {1'b0, prod_q} + {24'd0, it_q.chunk_length};
	assign ack_now  = (status_q == crwt_pkg::ST_DUP) || gaps || (gaps != gaps_q)
	                  || (base_q == cfg.chunk_total) || (uc_inc >= cfg.ack_count_limit)
	                  || (elapsed_q >= {16'd0, cfg.ack_delay_ticks});
	// A tick sends the delayed acknowledgement when chunks wait unacknowledged.
	assign tick_ack = (it_q.command == crwt_pkg::CMD_TICK) && active_q
	                  && (unacked_q != 8'd0) && (elapsed >= {16'd0, cfg.ack_delay_ticks});
	assign bad_size = (it_q.chunk_length == 11'd0)
	                  || ((it_q.chunk_num < cfg.chunk_total)
	                      && (it_q.chunk_length != cfg.chunk_bytes))
	                  || ((it_q.chunk_num == cfg.chunk_total)
	                      && (last_end > {11'd0, cfg.transfer_size}));

	// Number of bitmap words up to the highest nonzero one.
	always_comb begin
		nwords = '0;
		for (int i = 0; i < BITMAP_WORDS; i++) begin
			if (bmp_q[32*i +: 32] != 32'd0) begin
				nwords = NWW'(i + 1);
			end
		end
	end

	// Result beat assembly.
	always_comb begin
		out_res = '0;
		out_res.ack_base_index = base_q;
		out_res.active         = active_q;
		out_res.ack_sent       = ack_q;
		if (state_q == S_EMIT_W) begin
			out_res.kind     = crwt_pkg::KIND_WORD;
			out_res.ack_word = bmp_q[32*wi_q +: 32];
			out_res.last     = (wi_q == nwords - NWW'(1));
		end else begin
			out_res.kind             = crwt_pkg::KIND_STATUS;
			out_res.status           = status_q;
			out_res.save_chunk       = save_q;
			out_res.save_offset      = save_q ? soff_q : 24'd0;
			out_res.committed_offset = done_q;
			out_res.out_of_order     = ooo_q;
			out_res.transfer_done    = (base_q == cfg.chunk_total);
			out_res.last             = !(ack_q && (nwords != '0));
		end
	end

	assign in_take = (state_q == S_IDLE) && in_valid;
	assign out_wr  = ((state_q == S_EMIT_S) || (state_q == S_EMIT_W)) && !out_full;

	// Per-item scratch registers.
	always_ff @(posedge clk) begin
		if (in_take) begin
			it_q <= in_item;
		end
		if (state_q == S_EVAL) begin
			elapsed_q <= elapsed;
			prod_q    <= {11'd0, it_q.chunk_num - 23'd1} * {23'd0, cfg.chunk_bytes};
			rel_q     <= RELW'(it_q.chunk_num - base_q - 23'd1);
			below_q   <= (it_q.chunk_num <= base_q);
			outside_q <= ({1'b0, it_q.chunk_num} > win_end);
		end
	end

	// Sequencer and window state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			bmp_q       <= '0;
			base_q      <= '0;
			done_q      <= '0;
			unacked_q   <= '0;
			gaps_q      <= 1'b0;
			last_time_q <= '0;
			active_q    <= 1'b0;
			run_q       <= '0;
			status_q    <= crwt_pkg::ST_OK;
			save_q      <= 1'b0;
			soff_q      <= '0;
			ooo_q       <= 1'b0;
			ack_q       <= 1'b0;
			wi_q        <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EVAL;
					end
				end
				// Commands that need no window work finish here.
				S_EVAL: begin
					save_q <= 1'b0;
					ooo_q  <= 1'b0;
					ack_q  <= tick_ack;
					run_q  <= '0;
					if (it_q.command == crwt_pkg::CMD_START) begin
						bmp_q       <= '0;
						base_q      <= '0;
						done_q      <= cfg.start_offset;
						unacked_q   <= '0;
						gaps_q      <= 1'b0;
						last_time_q <= it_q.now_ticks;
						active_q    <= 1'b1;
						status_q    <= crwt_pkg::ST_OK;
						state_q     <= S_EMIT_S;
					end else if (!active_q) begin
						status_q <= crwt_pkg::ST_INACTIVE;
						state_q  <= S_EMIT_S;
					end else if (it_q.command == crwt_pkg::CMD_TICK) begin
						if (tick_ack) begin
							unacked_q <= '0;
						end
						if (elapsed >= cfg.timeout_ticks) begin
							active_q <= 1'b0;
							status_q <= crwt_pkg::ST_TIMEOUT;
						end else begin
							status_q <= crwt_pkg::ST_OK;
						end
						state_q <= S_EMIT_S;
					end else if ((it_q.chunk_num == 23'd0)
					             || (it_q.chunk_num > cfg.chunk_total)) begin
						active_q <= 1'b0;
						status_q <= crwt_pkg::ST_BAD_IDX;
						state_q  <= S_EMIT_S;
					end else begin
						state_q <= S_CHECK;
					end
				end
				// Size check, then classify against the window.
				S_CHECK: begin
					if (bad_size) begin
						active_q <= 1'b0;
						status_q <= crwt_pkg::ST_BAD_SIZE;
						state_q  <= S_EMIT_S;
					end else if (below_q) begin
						status_q <= crwt_pkg::ST_DUP;
						state_q  <= S_DECIDE;
					end else if (outside_q) begin
						status_q <= crwt_pkg::ST_OUTSIDE;
						state_q  <= S_DECIDE;
					end else if (bmp_q[rel_q]) begin
						status_q <= crwt_pkg::ST_DUP;
						state_q  <= S_DECIDE;
					end else begin
						status_q     <= crwt_pkg::ST_NEW;
						bmp_q[rel_q] <= 1'b1;
						save_q       <= 1'b1;
						soff_q       <= crwt_pkg::sat24(soff_sum);
						if (rel_q == '0) begin
							state_q <= S_SLIDE;
						end else begin
							ooo_q   <= !bmp_q[rel_q - RELW'(1)];
							state_q <= S_DECIDE;
						end
					end
				end
				// Slide the window one chunk a cycle over the received run.
				S_SLIDE: begin
					if (bmp_q[0]) begin
						bmp_q <= bmp_q >> 1;
						run_q <= run_q + RUNW'(1);
					end else begin
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					done_q  <= crwt_pkg::sat24((d_sum > file_end) ? file_end : d_sum);
					base_q  <= base_q + 23'(run_q);
					state_q <= S_DECIDE;
				end
				// Acknowledgement rule.
				S_DECIDE: begin
					ack_q       <= ack_now;
					unacked_q   <= ack_now ? 8'd0 : uc_inc;
					gaps_q      <= gaps;
					last_time_q <= it_q.now_ticks;
					state_q     <= S_EMIT_S;
				end
				S_EMIT_S: begin
					if (!out_full) begin
						wi_q <= '0;
						if (ack_q && (nwords != '0)) begin
							state_q <= S_EMIT_W;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_EMIT_W: begin
					if (!out_full) begin
						wi_q <= wi_q + NWW'(1);
						if (wi_q == nwords - NWW'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

FILE: hw/rtl/chunk_receive_window_tracker.sv
// Receive window of a selective-repeat chunk transfer. Input beats enter a
// two-entry queue; a sequencer works one item at a time and writes its results
// into a two-entry result queue. A start, tick, inactive or bad-index item goes
// from evaluation straight to its status beat; a bad-size chunk also passes the
// size check; a duplicate, outside or out-of-order new chunk then passes the
// ack decision. A new chunk at the window base also slides the window, one bit
// per cycle, over the received run and commits it before the decision. Each ack
// bitmap word adds a word beat, and a full result queue stalls the sequencer.
// Unknown commands are accepted and give no result.
module chunk_receive_window_tracker #(
	parameter int BITMAP_WORDS = crwt_pkg::BITMAP_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  command,
	input  logic [22:0] chunk_num,
	input  logic [10:0] chunk_length,
	input  logic [31:0] now_ticks,
	output logic        empty,
	input  logic        pop,
	output logic        kind,
	output logic [2:0]  status,
	output logic        save_chunk,
	output logic [23:0] save_offset,
	output logic [23:0] committed_offset,
	output logic        out_of_order,
	output logic        transfer_done,
	output logic        ack_sent,
	output logic [22:0] ack_base_index,
	output logic [31:0] ack_word,
	output logic        active,
	output logic        last
);
	crwt_pkg::cfg_t  cfg_q;
	crwt_pkg::item_t in_item;
	crwt_pkg::item_t head;
	crwt_pkg::res_t  core_res;
	crwt_pkg::res_t  res;
	logic            head_valid;
	logic            take;
	logic            res_wr;
	logic            res_full;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_offset    <= 24'd0;
			cfg_q.transfer_size   <= 24'd0;
			cfg_q.chunk_bytes     <= 11'd512;
			cfg_q.chunk_total     <= 23'd0;
			cfg_q.window_chunks   <= 8'd1;
			cfg_q.ack_count_limit <= 8'd8;
			cfg_q.ack_delay_ticks <= 16'd100;
			cfg_q.timeout_ticks   <= 32'd60000;
		end else if (cfg_write) begin
			case (cfg_index)
				crwt_pkg::REG_START_OFFSET:  cfg_q.start_offset    <= cfg_data[23:0];
				crwt_pkg::REG_TRANSFER_SIZE: cfg_q.transfer_size   <= cfg_data[23:0];
				crwt_pkg::REG_CHUNK_BYTES:   cfg_q.chunk_bytes     <= cfg_data[10:0];
				crwt_pkg::REG_CHUNK_TOTAL:   cfg_q.chunk_total     <= cfg_data[22:0];
				crwt_pkg::REG_WINDOW_CHUNKS: cfg_q.window_chunks   <= cfg_data[7:0];
				crwt_pkg::REG_ACK_LIMIT:     cfg_q.ack_count_limit <= cfg_data[7:0];
				crwt_pkg::REG_ACK_DELAY:     cfg_q.ack_delay_ticks <= cfg_data[15:0];
				crwt_pkg::REG_TIMEOUT:       cfg_q.timeout_ticks   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign in_item.command      = command;
	assign in_item.chunk_num    = chunk_num;
	assign in_item.chunk_length = chunk_length;
	assign in_item.now_ticks    = now_ticks;

	crwt_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (in_item),
		.valid  (head_valid),
		.head   (head),
		.take   (take)
	);

	crwt_core #(
		.BITMAP_WORDS (BITMAP_WORDS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (head_valid),
		.in_item  (head),
		.in_take  (take),
		.out_full (res_full),
		.out_wr   (res_wr),
		.out_res  (core_res)
	);

	crwt_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_wr),
		.wdata  (core_res),
		.full   (res_full),
		.empty  (empty),
		.pop    (pop),
		.rdata  (res)
	);

	assign kind             = res.kind;
	assign status           = res.status;
	assign save_chunk       = res.save_chunk;
	assign save_offset      = res.save_offset;
	assign committed_offset = res.committed_offset;
	assign out_of_order     = res.out_of_order;
	assign transfer_done    = res.transfer_done;
	assign ack_sent         = res.ack_sent;
	assign ack_base_index   = res.ack_base_index;
	assign ack_word         = res.ack_word;
	assign active           = res.active;
	assign last             = res.last;

`ifndef ASSERT_OFF
	// A bitmap word beat only belongs to an acknowledgement.
	a_word_has_ack: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (kind == crwt_pkg::KIND_WORD) |-> ack_sent)
		else $error("ack word beat without ack_sent");

	// Only a new chunk is stored.
	a_save_is_new: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && save_chunk |-> (kind == crwt_pkg::KIND_STATUS)
			&& (status == crwt_pkg::ST_NEW))
		else $error("save_chunk on a beat that is not a new chunk");

	// A chunk error or timeout ends the transfer.
	a_error_ends: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (kind == crwt_pkg::KIND_STATUS)
			&& ((status == crwt_pkg::ST_BAD_IDX) || (status == crwt_pkg::ST_BAD_SIZE)
			|| (status == crwt_pkg::ST_TIMEOUT)) |-> !active)
		else $error("transfer still active after an error status");
`endif
endmodule

FILE: bench/tb_chunk_receive_window_tracker.sv
module tb_chunk_receive_window_tracker;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NWORDS = crwt_pkg::BITMAP_WORDS_DEF;
	localparam int WIN_MAX = NWORDS * 32;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 300;

	// Tracks the receive window as the block should see it and holds the
	// results that are still to come out of the block.
	class window_scoreboard;
		crwt_pkg::cfg_t cfg;
		logic [31:0]    bitmap [NWORDS];
		logic [22:0]    base;
		logic [23:0]    done;
		int             unacked;
		bit             gaps_seen;
		logic [31:0]    last_stamp;
		bit             live;
		crwt_pkg::res_t awaited [$];
		int             errors;

		function new();
			cfg.start_offset    = '0;
			cfg.transfer_size   = '0;
			cfg.chunk_bytes     = 11'd512;
			cfg.chunk_total     = '0;
			cfg.window_chunks   = 8'd1;
			cfg.ack_count_limit = 8'd8;
			cfg.ack_delay_ticks = 16'd100;
			cfg.timeout_ticks   = 32'd60000;
			foreach (bitmap[i]) bitmap[i] = '0;
			base = '0;
			done = '0;
			unacked = 0;
			gaps_seen = 0;
			last_stamp = '0;
			live = 0;
			errors = 0;
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		function void set_reg(logic [2:0] idx, logic [31:0] data);
			case (idx)
				crwt_pkg::REG_START_OFFSET:  cfg.start_offset = data[23:0];
				crwt_pkg::REG_TRANSFER_SIZE: cfg.transfer_size = data[23:0];
				crwt_pkg::REG_CHUNK_BYTES:   cfg.chunk_bytes = data[10:0];
				crwt_pkg::REG_CHUNK_TOTAL:   cfg.chunk_total = data[22:0];
				crwt_pkg::REG_WINDOW_CHUNKS: cfg.window_chunks = data[7:0];
				crwt_pkg::REG_ACK_LIMIT:     cfg.ack_count_limit = data[7:0];
				crwt_pkg::REG_ACK_DELAY:     cfg.ack_delay_ticks = data[15:0];
				crwt_pkg::REG_TIMEOUT:       cfg.timeout_ticks = data;
				default: ;
			endcase
		endfunction

		function int eff_window();
			return (cfg.window_chunks > WIN_MAX) ? WIN_MAX : int'(cfg.window_chunks);
		endfunction

		function logic [23:0] clamp24(longint v);
			return (v > 64'hFFFFFF) ? crwt_pkg::MAX24 : v[23:0];
		endfunction

		// Queues the status beat and, with an ack, the bitmap words up to the
		// highest nonzero one.
		function void emit(logic [2:0] st, bit save, logic [23:0] soff, bit ooo, bit ack);
			crwt_pkg::res_t r;
			int             words;
			r = '0;
			r.kind = crwt_pkg::KIND_STATUS;
			r.status = st;
			r.save_chunk = save;
			r.save_offset = save ? soff : '0;
			r.committed_offset = done;
			r.out_of_order = ooo;
			r.transfer_done = (base == cfg.chunk_total);
			r.ack_sent = ack;
			r.ack_base_index = base;
			r.active = live;
			words = 0;
			if (ack) begin
				for (int i = NWORDS - 1; i >= 0; i--) begin
					if (bitmap[i] != 0) begin
						words = i + 1;
						break;
					end
				end
			end
			r.last = (words == 0);
			awaited.push_back(r);
			for (int i = 0; i < words; i++) begin
				r = '0;
				r.kind = crwt_pkg::KIND_WORD;
				r.ack_sent = 1'b1;
				r.ack_base_index = base;
				r.ack_word = bitmap[i];
				r.active = live;
				r.last = (i == words - 1);
				awaited.push_back(r);
			end
		endfunction

		function bit bit_at(int pos);
			return bitmap[pos / 32][pos % 32];
		endfunction

		// Works out the results of one accepted input beat.
		function void note_item(crwt_pkg::item_t it);
			logic [31:0] elapsed;
			int          win, rel, run;
			logic [2:0]  st;
			bit          save, ooo, ack, gaps;
			logic [23:0] soff;
			longint      file_end, reach;
			elapsed = it.now_ticks - last_stamp;
			if (it.command == crwt_pkg::CMD_START) begin
				foreach (bitmap[i]) bitmap[i] = '0;
				base = '0;
				done = cfg.start_offset;
				unacked = 0;
				gaps_seen = 0;
				last_stamp = it.now_ticks;
				live = 1;
				emit(crwt_pkg::ST_OK, 0, '0, 0, 0);
				return;
			end
			if (it.command == crwt_pkg::CMD_NONE) return;
			if (!live) begin
				emit(crwt_pkg::ST_INACTIVE, 0, '0, 0, 0);
				return;
			end
			if (it.command == crwt_pkg::CMD_TICK) begin
				ack = 0;
				if (unacked > 0 && elapsed >= cfg.ack_delay_ticks) begin
					ack = 1;
					unacked = 0;
				end
				if (elapsed >= cfg.timeout_ticks) begin
					live = 0;
					emit(crwt_pkg::ST_TIMEOUT, 0, '0, 0, ack);
				end else begin
					emit(crwt_pkg::ST_OK, 0, '0, 0, ack);
				end
				return;
			end

			// Chunk beat: index and size checks end the transfer.
			if (it.chunk_num == 0 || it.chunk_num > cfg.chunk_total) begin
				live = 0;
				emit(crwt_pkg::ST_BAD_IDX, 0, '0, 0, 0);
				return;
			end
			if (it.chunk_length == 0 ||
			    (it.chunk_num < cfg.chunk_total && it.chunk_length != cfg.chunk_bytes) ||
			    (it.chunk_num == cfg.chunk_total &&
			     longint'(it.chunk_num - 1) * cfg.chunk_bytes + it.chunk_length >
			     longint'(cfg.transfer_size))) begin
				live = 0;
				emit(crwt_pkg::ST_BAD_SIZE, 0, '0, 0, 0);
				return;
			end

			win = eff_window();
			save = 0;
			ooo = 0;
			soff = '0;
			if (it.chunk_num <= base) begin
				st = crwt_pkg::ST_DUP;
			end else if (longint'(it.chunk_num) > longint'(base) + win) begin
				st = crwt_pkg::ST_OUTSIDE;
			end else begin
				rel = it.chunk_num - base - 1;
				if (bit_at(rel)) begin
					st = crwt_pkg::ST_DUP;
				end else begin
					st = crwt_pkg::ST_NEW;
					bitmap[rel / 32][rel % 32] = 1'b1;
					save = 1;
					soff = clamp24(longint'(done) + longint'(rel) * cfg.chunk_bytes);
					if (rel == 0) begin
						// Slide the window over the run of received chunks.
						run = 0;
						while (bitmap[0][0]) begin
							for (int i = 0; i < NWORDS; i++)
								bitmap[i] = {(i + 1 < NWORDS) ? bitmap[i + 1][0] : 1'b0,
								             bitmap[i][31:1]};
							run++;
						end
						file_end = longint'(cfg.start_offset) + cfg.transfer_size;
						reach = longint'(done) + longint'(run) * cfg.chunk_bytes;
						if (reach > file_end) reach = file_end;
						done = clamp24(reach);
						base = base + 23'(run);
					end else if (!bit_at(rel - 1)) begin
						ooo = 1;
					end
				end
			end

			gaps = 0;
			foreach (bitmap[i]) if (bitmap[i] != 0) gaps = 1;
			if (unacked < 255) unacked++;
			ack = (st == crwt_pkg::ST_DUP) || gaps || (gaps != gaps_seen) ||
			      (base == cfg.chunk_total) || (unacked >= cfg.ack_count_limit) ||
			      (elapsed >= cfg.ack_delay_ticks);
			if (ack) unacked = 0;
			gaps_seen = gaps;
			last_stamp = it.now_ticks;
			emit(st, save, soff, ooo, ack);
		endfunction

		task field(string name, longint got, longint want);
			if (got != want) report($sformatf("%s got %0h expected %0h", name, got, want));
		endtask

		// Compares one popped result beat with the oldest expectation.
		task check_result(crwt_pkg::res_t got);
			crwt_pkg::res_t want;
			if (awaited.size() == 0) begin
				report("result beat with nothing expected");
				return;
			end
			want = awaited.pop_front();
			field("kind", got.kind, want.kind);
			field("status", got.status, want.status);
			field("save_chunk", got.save_chunk, want.save_chunk);
			field("save_offset", got.save_offset, want.save_offset);
			field("committed_offset", got.committed_offset, want.committed_offset);
			field("out_of_order", got.out_of_order, want.out_of_order);
			field("transfer_done", got.transfer_done, want.transfer_done);
			field("ack_sent", got.ack_sent, want.ack_sent);
			field("ack_base_index", got.ack_base_index, want.ack_base_index);
			field("ack_word", got.ack_word, want.ack_word);
			field("active", got.active, want.active);
			field("last", got.last, want.last);
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_write;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        push, full;
	logic [1:0]  command;
	logic [22:0] chunk_num;
	logic [10:0] chunk_length;
	logic [31:0] now_ticks;
	logic        empty, pop;
	logic        kind;
	logic [2:0]  status;
	logic        save_chunk;
	logic [23:0] save_offset;
	logic [23:0] committed_offset;
	logic        out_of_order, transfer_done, ack_sent;
	logic [22:0] ack_base_index;
	logic [31:0] ack_word;
	logic        active, last;

	window_scoreboard sb = new();
	logic [31:0] clock_ms;
	int          cycles;
	int          beats_popped;
	bit          held_once;

	chunk_receive_window_tracker DUT (.*);

	always #5 clk = ~clk;

	// Watch both handshakes at each edge.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
		if (arst_n && push && !full)
			sb.note_item('{command, chunk_num, chunk_length, now_ticks});
		if (arst_n && pop && !empty) begin
			sb.check_result('{kind, status, save_chunk, save_offset, committed_offset,
			                  out_of_order, transfer_done, ack_sent, ack_base_index,
			                  ack_word, active, last});
			beats_popped++;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Receiver: random stalls, plus one long hold-off to fill the block.
	initial begin
		int stall;
		stall = 0;
		pop <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held_once && beats_popped >= 150) begin
				held_once = 1;
				pop <= 1'b0;
				repeat (3000) @(posedge clk);
			end
			if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else begin
				pop <= 1'b1;
				if ($urandom_range(0, 7) == 0) stall = gap_len();
			end
		end
	end

	task automatic send_item(logic [1:0] cmd, logic [22:0] idx, logic [10:0] len,
	                         logic [31:0] stamp);
		push <= 1'b1;
		command <= cmd;
		chunk_num <= idx;
		chunk_length <= len;
		now_ticks <= stamp;
		do @(posedge clk); while (full);
	endtask

	task automatic sender_gap();
		int n;
		n = gap_len();
		if (n > 0) begin
			push <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Waits until every expected beat is out and the sequencer has gone quiet.
	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.set_reg(idx, data);
		@(posedge clk);
	endtask

	task automatic load_setup(logic [23:0] so, logic [23:0] ts, logic [10:0] cb,
	                          logic [22:0] total, logic [7:0] win, logic [7:0] lim,
	                          logic [15:0] dly, logic [31:0] tmo);
		write_reg(crwt_pkg::REG_START_OFFSET, {8'd0, so});
		write_reg(crwt_pkg::REG_TRANSFER_SIZE, {8'd0, ts});
		write_reg(crwt_pkg::REG_CHUNK_BYTES, {21'd0, cb});
		write_reg(crwt_pkg::REG_CHUNK_TOTAL, {9'd0, total});
		write_reg(crwt_pkg::REG_WINDOW_CHUNKS, {24'd0, win});
		write_reg(crwt_pkg::REG_ACK_LIMIT, {24'd0, lim});
		write_reg(crwt_pkg::REG_ACK_DELAY, {16'd0, dly});
		write_reg(crwt_pkg::REG_TIMEOUT, tmo);
		cfg_write <= 1'b0;
	endtask

	// Correct payload length for a chunk index under the current setup.
	function automatic logic [10:0] proper_len(logic [22:0] idx);
		longint rest;
		if (idx != sb.cfg.chunk_total) return sb.cfg.chunk_bytes;
		rest = longint'(sb.cfg.transfer_size) - longint'(idx - 1) * sb.cfg.chunk_bytes;
		if (rest < 1 || rest > 2047) return sb.cfg.chunk_bytes;
		return rest[10:0];
	endfunction

	// Mostly well-formed chunks inside the window, with ticks, restarts and noise.
	task automatic run_session(int count, int step_max);
		int          r, hi;
		logic [22:0] idx;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 49) == 0) clock_ms = clock_ms + $urandom;
			else clock_ms = clock_ms + $urandom_range(0, step_max);
			r = $urandom_range(0, 99);
			if (!sb.live || r < 3 || (sb.base == sb.cfg.chunk_total && r < 30)) begin
				send_item(crwt_pkg::CMD_START, 23'($urandom), 11'($urandom), clock_ms);
			end else if (r < 80) begin
				hi = sb.base + sb.eff_window();
				if (hi > sb.cfg.chunk_total) hi = sb.cfg.chunk_total;
				if (r < 72 && hi > sb.base) idx = 23'($urandom_range(sb.base + 1, hi));
				else if (r < 76)
					idx = 23'(sb.base + sb.eff_window() + $urandom_range(1, 3));
				else idx = (sb.base > 0) ? 23'($urandom_range(1, sb.base)) : sb.base + 23'd1;
				if (idx > sb.cfg.chunk_total) idx = sb.cfg.chunk_total;
				send_item(crwt_pkg::CMD_CHUNK, idx, proper_len(idx), clock_ms);
			end else if (r < 92) begin
				send_item(crwt_pkg::CMD_TICK, 23'($urandom), 11'($urandom), clock_ms);
			end else if (r < 95) begin
				send_item(crwt_pkg::CMD_NONE, 23'($urandom), 11'($urandom), $urandom);
			end else begin
				send_item(crwt_pkg::CMD_CHUNK, 23'($urandom), 11'($urandom_range(0, 2047)),
				          clock_ms);
			end
			sender_gap();
		end
		settle();
	endtask

	initial begin
		clk = 1'b0;
		cycles = 0;
		beats_popped = 0;
		held_once = 0;
		clock_ms = '0;
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		push <= 1'b0;
		command <= crwt_pkg::CMD_NONE;
		chunk_num <= '0;
		chunk_length <= '0;
		now_ticks <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: inactive beats, saturated offsets, window edges, bad chunks.
		send_item(crwt_pkg::CMD_TICK, 23'd0, 11'd0, 32'd5);
		send_item(crwt_pkg::CMD_CHUNK, 23'd1, 11'd512, 32'd6);
		send_item(crwt_pkg::CMD_NONE, '1, '1, '1);
		settle();
		load_setup(24'hFFFFF0, 24'd3000, 11'd1024, 23'd3, 8'd2, 8'd1, 16'd0, 32'd1);
		send_item(crwt_pkg::CMD_START, 23'd0, 11'd0, 32'd0);
		send_item(crwt_pkg::CMD_CHUNK, 23'd2, 11'd1024, 32'd0);
		send_item(crwt_pkg::CMD_CHUNK, 23'd2, 11'd1024, 32'd0);
		send_item(crwt_pkg::CMD_CHUNK, 23'd3, 11'd952, 32'd0);
		send_item(crwt_pkg::CMD_CHUNK, 23'd1, 11'd1024, 32'd0);
		send_item(crwt_pkg::CMD_CHUNK, 23'd3, 11'd952, 32'd0);
		send_item(crwt_pkg::CMD_TICK, 23'd0, 11'd0, 32'hFFFFFFFF);
		send_item(crwt_pkg::CMD_START, 23'd0, 11'd0, 32'd10);
		send_item(crwt_pkg::CMD_CHUNK, 23'd0, 11'd1024, 32'd10);
		send_item(crwt_pkg::CMD_START, 23'd0, 11'd0, 32'd11);
		send_item(crwt_pkg::CMD_CHUNK, 23'd4, 11'd1024, 32'd11);
		send_item(crwt_pkg::CMD_START, 23'd0, 11'd0, 32'd12);
		send_item(crwt_pkg::CMD_CHUNK, 23'd1, 11'd0, 32'd12);
		send_item(crwt_pkg::CMD_START, 23'd0, 11'd0, 32'd13);
		send_item(crwt_pkg::CMD_CHUNK, 23'd1, 11'd1000, 32'd13);
		send_item(crwt_pkg::CMD_START, 23'd0, 11'd0, 32'd14);
		send_item(crwt_pkg::CMD_CHUNK, 23'd3, 11'd953, 32'd14);
		send_item(crwt_pkg::CMD_START, 23'd0, 11'd0, 32'd15);
		send_item(crwt_pkg::CMD_START, 23'd0, 11'd0, 32'd16);
		send_item(crwt_pkg::CMD_CHUNK, 23'h7FFFFF, 11'h7FF, 32'd16);
		settle();

		// Random sessions over several setups, extremes among them.
		clock_ms = 32'd1000;
		load_setup(24'd0, 24'd100000, 11'd512, 23'd196, 8'd64, 8'd8, 16'd100, 32'd60000);
		run_session(120, 150);
		load_setup(24'h123456, 24'd158, 11'd4, 23'd40, 8'd255, 8'd255, 16'hFFFF,
		           32'hFFFFFFFF);
		run_session(110, 1000);
		load_setup(24'hFFF000, 24'hFFFFFF, 11'd1024, 23'd16384, 8'd128, 8'd1, 16'd0,
		           32'd5000);
		run_session(100, 50);
		load_setup(24'd0, 24'd1950, 11'd100, 23'd20, 8'd1, 8'd3, 16'd10, 32'd200);
		run_session(90, 30);
		load_setup(24'hAAAAAA, 24'h555555, 11'd8, 23'd4194304, 8'd32, 8'd2, 16'd50,
		           32'd1000);
		run_session(80, 80);

		if (sb.errors == 0 && sb.awaited.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
